FILE: rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and codes of the first-fit range allocator
// Status codes and the cell command struct used by the free-range cells.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // width of the managed address space
  localparam int ADDR_BITS = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_SHIFT  = 2'd2
  } cell_cmd_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic  insert_en;
    logic  alloc_en;
    logic  merge_en;
    logic  collapse_en;
  } cell_ctl_t;

endpackage

FILE: rtl/core/ffra_cell.sv
// ----------------------------------------------------------------------------
// ffra_cell: one free-range table entry
// Holds a start and a length, loads a new entry on insert, allocate or merge
// and takes its neighbour's entry on insert or removal shifts.
// ----------------------------------------------------------------------------
module ffra_cell import ffra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 here,
  input  logic                 shift_up,
  input  logic                 shift_dn,
  input  logic [ADDR_BITS-1:0] lo_start,
  input  logic [ADDR_BITS-1:0] lo_len,
  input  logic [ADDR_BITS-1:0] hi_start,
  input  logic [ADDR_BITS-1:0] hi_len,
  input  logic [ADDR_BITS-1:0] new_start,
  input  logic [ADDR_BITS-1:0] new_len,
  output logic [ADDR_BITS-1:0] start_q,
  output logic [ADDR_BITS-1:0] len_q
);

  logic [ADDR_BITS-1:0] start_r, start_nxt;
  logic [ADDR_BITS-1:0] len_r, len_nxt;

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    if (shift_up) begin
      start_nxt = lo_start;
      len_nxt   = lo_len;
    end else if (shift_dn) begin
      start_nxt = hi_start;
      len_nxt   = hi_len;
    end else if (here && (ctl.insert_en || ctl.alloc_en || ctl.merge_en)) begin
      start_nxt = new_start;
      len_nxt   = new_len;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  assign start_q = start_r;
  assign len_q   = len_r;

  // rst_n unused by payload, kept for uniform cell ports
  logic unused_rst;
  assign unused_rst = rst_n ^ ctl.collapse_en;

endmodule

FILE: rtl/core/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit range allocator with coalescing
// A row of free-range cells, a high-water mark and a small sequencer.
// ----------------------------------------------------------------------------
// sequence: an input transfer passes S_SCAN and S_ACT to S_DONE for allocate and insert;
//   a release merging k+1 entries also passes S_COLL for its k removals (one removal per cycle)
// flow: one item at a time; the next input transfer is taken once the previous result
//   has moved to the output register, later while a result stalls
// reset: entry count and high-water mark clear to zero, no table sweep
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int MAX_RANGES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [31:0]          in_count,
  input  logic [31:0]          in_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_alloc_offset,
  output logic [1:0]           out_status
);

  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam logic [ADDR_BITS:0] LIMIT = {1'b0, {ADDR_BITS{1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_COLL, S_DONE} state_t;

  state_t                state_r;
  logic [CW-1:0]         used_r;
  logic [ADDR_BITS-1:0]  mark_r;
  logic                  op_r;
  logic [ADDR_BITS:0]    cnt_r, s_r, e_r;
  logic [IW:0]           lo_r, hi_r;
  logic                  fit_r;
  logic [IW-1:0]         fit_idx_r;
  logic [31:0]           pend_off_r;
  status_t               pend_st_r;
  logic [31:0]           res_off_r;
  status_t               res_st_r;
  logic                  out_valid_r;

  logic [ADDR_BITS-1:0] c_start [MAX_RANGES];
  logic [ADDR_BITS-1:0] c_len   [MAX_RANGES];
  logic [MAX_RANGES-1:0] fit_v, below_v, le_v;

  // parallel compares against every cell
  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      fit_v[i]   = (CW'(i) < used_r) && ({1'b0, c_len[i]} >= cnt_r);
      below_v[i] = (CW'(i) < used_r) &&
                   (({1'b0, c_start[i]} + {1'b0, c_len[i]}) < s_r);
      le_v[i]    = (CW'(i) < used_r) && ({1'b0, c_start[i]} <= e_r);
    end
  end

  // first fit, count of entries below, count of entries starting at or below e
  logic [IW-1:0] ff_idx;
  logic          ff_any;
  logic [IW:0]   n_below, n_le;
  always_comb begin
    ff_idx  = '0;
    ff_any  = 1'b0;
    n_below = '0;
    n_le    = '0;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (fit_v[i]) begin
        ff_idx = IW'(i);
        ff_any = 1'b1;
      end
    end
    for (int i = 0; i < MAX_RANGES; i++) begin
      n_below = n_below + (IW+1)'(below_v[i]);
      n_le    = n_le + (IW+1)'(le_v[i]);
    end
  end

  // cell control
  cell_ctl_t            ctl;
  logic [IW-1:0]        tgt;
  logic [ADDR_BITS-1:0] new_start, new_len;
  logic                 do_ins, do_coll, rm_fit;
  logic [ADDR_BITS:0]   ns, ne, lo_end;
  logic [IW-1:0]        lo_i, hm1_i;

  assign lo_i   = lo_r[IW-1:0];
  assign hm1_i  = IW'(hi_r - 1'b1);
  assign lo_end = {1'b0, c_start[hm1_i]} + {1'b0, c_len[hm1_i]};
  assign ns = ({1'b0, c_start[lo_i]} < s_r) ? {1'b0, c_start[lo_i]} : s_r;
  assign ne = (lo_end > e_r) ? lo_end : e_r;

  always_comb begin
    ctl       = '0;
    tgt       = '0;
    new_start = '0;
    new_len   = '0;
    do_ins    = 1'b0;
    do_coll   = 1'b0;
    rm_fit    = 1'b0;
    if (state_r == S_ACT) begin
      if (!op_r) begin
        if (fit_r) begin
          tgt       = fit_idx_r;
          new_start = ADDR_BITS'({1'b0, c_start[fit_idx_r]} + cnt_r);
          new_len   = ADDR_BITS'({1'b0, c_len[fit_idx_r]} - cnt_r);
          rm_fit    = (new_len == '0);
          ctl.alloc_en = !rm_fit;
        end
      end else if (cnt_r != '0) begin
        if (hi_r > lo_r) begin
          tgt          = lo_i;
          new_start    = ADDR_BITS'(ns);
          new_len      = ADDR_BITS'(ne - ns);
          ctl.merge_en = 1'b1;
        end else if (used_r < CW'(MAX_RANGES)) begin
          tgt           = lo_i;
          new_start     = ADDR_BITS'(s_r);
          new_len       = ADDR_BITS'(e_r - s_r);
          ctl.insert_en = 1'b1;
          do_ins        = 1'b1;
        end
      end
    end else if (state_r == S_COLL) begin
      do_coll         = 1'b1;
      ctl.collapse_en = 1'b1;
    end
  end

  // removal position: fit entry on alloc, lo+1 on collapse
  logic [IW:0] rm_at;
  assign rm_at = do_coll ? (lo_r + 1'b1) : {1'b0, fit_idx_r};

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    logic sh_up, sh_dn;
    assign sh_up = do_ins && (g > 0) && ((IW+1)'(g) > lo_r) && (CW'(g) <= used_r);
    assign sh_dn = (do_coll || rm_fit) && ((IW+1)'(g) >= rm_at) &&
                   (g < MAX_RANGES - 1);
    ffra_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .here      (tgt == IW'(g)),
      .shift_up  (sh_up),
      .shift_dn  (sh_dn),
      .lo_start  (c_start[(g > 0) ? g - 1 : 0]),
      .lo_len    (c_len[(g > 0) ? g - 1 : 0]),
      .hi_start  (c_start[(g < MAX_RANGES - 1) ? g + 1 : g]),
      .hi_len    (c_len[(g < MAX_RANGES - 1) ? g + 1 : g]),
      .new_start (new_start),
      .new_len   (new_len),
      .start_q   (c_start[g]),
      .len_q     (c_len[g])
    );
  end

  logic in_xfer, out_xfer, res_load;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  // finished item moves to the output register once that is free
  assign res_load = (state_r == S_DONE) && (!out_valid_r || out_xfer);

  logic [ADDR_BITS:0] in_cnt_w, in_off_w, room;
  assign in_cnt_w = {1'b0, ADDR_BITS'(in_count)};
  assign in_off_w = {1'b0, ADDR_BITS'(in_offset)};
  assign room     = LIMIT - in_off_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r  <= in_op;
            s_r   <= in_off_w;
            e_r   <= in_off_w + ((in_cnt_w > room) ? room : in_cnt_w);
            // a release with zero count or at the limit carries count zero
            cnt_r <= (in_op && (in_count == '0 || in_off_w >= LIMIT)) ? '0 : in_cnt_w;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          fit_r     <= ff_any;
          fit_idx_r <= ff_idx;
          lo_r      <= n_below;
          hi_r      <= n_le;
          state_r   <= S_ACT;
        end
        S_ACT: begin
          if (!op_r) begin
            state_r <= S_DONE;
            if (cnt_r == '0) begin
              pend_off_r <= '0;
              pend_st_r  <= ST_ZERO;
            end else if (fit_r) begin
              pend_off_r <= 32'(c_start[fit_idx_r]);
              pend_st_r  <= ST_OK;
              if (rm_fit) used_r <= used_r - 1'b1;
            end else if (cnt_r > LIMIT - {1'b0, mark_r}) begin
              pend_off_r <= '0;
              pend_st_r  <= ST_EXHAUSTED;
            end else begin
              pend_off_r <= 32'(mark_r);
              pend_st_r  <= ST_OK;
              mark_r     <= ADDR_BITS'({1'b0, mark_r} + cnt_r);
            end
          end else begin
            pend_off_r <= '0;
            if (cnt_r == '0) begin
              pend_st_r <= ST_OK;
              state_r   <= S_DONE;
            end else if (hi_r > lo_r) begin
              pend_st_r <= ST_OK;
              state_r   <= (hi_r - lo_r > (IW+1)'(1)) ? S_COLL : S_DONE;
            end else if (used_r < CW'(MAX_RANGES)) begin
              pend_st_r <= ST_OK;
              used_r    <= used_r + 1'b1;
              state_r   <= S_DONE;
            end else begin
              pend_st_r <= ST_FULL;
              state_r   <= S_DONE;
            end
          end
        end
        S_COLL: begin
          used_r <= used_r - 1'b1;
          hi_r   <= hi_r - 1'b1;
          if (hi_r - lo_r <= (IW+1)'(2)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            res_off_r <= pend_off_r;
            res_st_r  <= pend_st_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alloc_offset = res_off_r;
  assign out_status       = res_st_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_RANGES)) else $error("entry count beyond table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("transfer taken while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_valid_r |=> out_valid_r)
    else $error("result lost");
`endif

endmodule
